[src/sdr_pkg.sv]
`timescale 1ns / 1ps

package sdr_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CountWidth = 16;
  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic                         end_of_list;
  } in_word_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0] out_value;
    logic                         kept;
    logic [CountWidth-1:0]        removed_count;
    logic                         table_overflow;
    logic                         last;
  } out_word_t;

  // word in flight along the cell chain
  typedef struct packed {
    logic                         valid;
    logic signed [ValueWidth-1:0] value;
    logic                         last;
    logic                         hit;
    logic                         stored;
  } item_t;

endpackage

[src/sdr_cell.sv]
`timescale 1ns / 1ps

module sdr_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          advance_i,
  input  sdr_pkg::item_t item_i,
  output sdr_pkg::item_t item_o
);

  logic                                  entry_valid_q;
  logic signed [sdr_pkg::ValueWidth-1:0] entry_value_q;
  logic                                  match;
  logic                                  take;
  sdr_pkg::item_t                        item_d;
  sdr_pkg::item_t                        item_q;

  always_comb begin
    match       = item_i.valid & entry_valid_q & (entry_value_q == item_i.value);
    take        = item_i.valid & ~entry_valid_q & ~item_i.hit & ~item_i.stored;
    item_d      = item_i;
    item_d.hit    = item_i.hit | match;
    item_d.stored = item_i.stored | take;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q        <= '0;
      entry_valid_q <= 1'b0;
    end else if (advance_i) begin
      item_q <= item_d;
      // clear behind the final word of a list
      if (item_i.valid && item_i.last) begin
        entry_valid_q <= 1'b0;
      end else if (take) begin
        entry_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && take) begin
      entry_value_q <= item_i.value;
    end
  end

  assign item_o = item_q;

endmodule

[src/sdr_out_stage.sv]
`timescale 1ns / 1ps

module sdr_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  sdr_pkg::item_t     item_i,
  output logic               out_valid_o,
  output sdr_pkg::out_word_t out_word_o
);

  logic [sdr_pkg::CountWidth-1:0] count_q;
  logic [sdr_pkg::CountWidth-1:0] count_d;
  logic                           ovf_q;
  logic                           ovf_d;
  logic                           out_valid_q;
  sdr_pkg::out_word_t             out_q;
  sdr_pkg::out_word_t             out_d;

  always_comb begin
    count_d = count_q;
    if (item_i.hit && (count_q != sdr_pkg::CountMax)) begin
      count_d = count_q + sdr_pkg::CountWidth'(1);
    end
    ovf_d                = ovf_q | (~item_i.hit & ~item_i.stored);
    out_d.out_value      = item_i.value;
    out_d.kept           = ~item_i.hit;
    out_d.removed_count  = count_d;
    out_d.table_overflow = ovf_d;
    out_d.last           = item_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
    end else if (advance_i) begin
      out_valid_q <= item_i.valid;
      if (item_i.valid) begin
        if (item_i.last) begin
          count_q <= '0;
          ovf_q   <= 1'b0;
        end else begin
          count_q <= count_d;
          ovf_q   <= ovf_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && item_i.valid) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

[src/stream_duplicate_remover.sv]
`timescale 1ns / 1ps

// Duplicate filter for a stream of signed 32-bit words, grouped into lists.
// Input channel: in_valid_i / in_stall_o / in_word_i (value, end_of_list).
// Output channel: out_valid_o / out_stall_i / out_word_o, one word per input
// word: the value, kept (no earlier copy stored in its list), the saturating count
// of duplicates dropped so far in the list, the sticky table overflow flag and
// the last flag.
// Words travel through a row of TABLE_DEPTH compare cells, one cell per cycle
// while the row is not held; each cell stores one distinct value of the current
// list. Each word is registered in every cell, then in the output stage that
// drives out_valid_o; one word is taken every cycle while the receiver does not stall.
// The last word of a list clears each cell as it passes it, so the next list
// may follow right behind it.
// While out_valid_o is high and out_stall_i is high the whole row holds and
// in_stall_o is high.
// Reset empties all cells, clears the count and overflow flag and drops any
// words in flight.
module stream_duplicate_remover #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sdr_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sdr_pkg::out_word_t out_word_o
);

  sdr_pkg::item_t chain [TABLE_DEPTH+1];
  logic           advance;

  assign advance    = ~out_valid_o | ~out_stall_i;
  assign in_stall_o = ~advance;

  always_comb begin
    chain[0].valid  = in_valid_i;
    chain[0].value  = in_word_i.value;
    chain[0].last   = in_word_i.end_of_list;
    chain[0].hit    = 1'b0;
    chain[0].stored = 1'b0;
  end

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    sdr_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .item_i    (chain[k]),
      .item_o    (chain[k+1])
    );
  end

  sdr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .item_i      (chain[TABLE_DEPTH]),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

[src/sdr_checker.sv]
`timescale 1ns / 1ps

module sdr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input sdr_pkg::out_word_t out_word_o
);

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  a_freeze : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output stalled");

  a_drop_counted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.kept |-> out_word_o.removed_count != '0)
    else $error("dropped word with zero removed count");

  a_idle_no_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

bind stream_duplicate_remover sdr_checker u_sdr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int Depth = 64;
  localparam int IdleLimit = 4000;
  localparam int RandomWords = 650;

  typedef struct {
    sdr_pkg::in_word_t  w;
    bit                 chk;
    sdr_pkg::out_word_t want;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  sdr_pkg::in_word_t  in_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  sdr_pkg::out_word_t out_word;

  bit        idle_on = 1'b0;
  int        stall_left = 0;
  int        idle_cycles = 0;
  int        err_count = 0;

  logic [sdr_pkg::ValueWidth-1:0] seen_tab [Depth];
  bit                             seen_ok  [Depth];
  logic [sdr_pkg::CountWidth-1:0] dup_total = '0;
  bit                             tab_full = 1'b0;

  sdr_pkg::out_word_t expected_words [$];
  dir_row_t           steps [$];
  sdr_pkg::out_word_t oldest;

  stream_duplicate_remover #(
    .TABLE_DEPTH(Depth)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic sdr_pkg::out_word_t dedup_predict(sdr_pkg::in_word_t w);
    sdr_pkg::out_word_t r;
    bit                 hit;
    int                 slot;
    hit = 1'b0;
    slot = -1;
    for (int i = 0; i < Depth; i++) begin
      if (seen_ok[i]) begin
        if (seen_tab[i] == w.value) hit = 1'b1;
      end else if (slot < 0) begin
        slot = i;
      end
    end
    if (hit) begin
      if (dup_total != sdr_pkg::CountMax) dup_total = dup_total + sdr_pkg::CountWidth'(1);
    end else if (slot >= 0) begin
      seen_tab[slot] = w.value;
      seen_ok[slot] = 1'b1;
    end else begin
      tab_full = 1'b1;
    end
    r.out_value      = w.value;
    r.kept           = !hit;
    r.removed_count  = dup_total;
    r.table_overflow = tab_full;
    r.last           = w.end_of_list;
    if (w.end_of_list) begin
      foreach (seen_ok[i]) seen_ok[i] = 1'b0;
      dup_total = '0;
      tab_full = 1'b0;
    end
    return r;
  endfunction

  function automatic dir_row_t row(logic [sdr_pkg::ValueWidth-1:0] v, logic eol, bit chk,
                                   logic kept, logic [sdr_pkg::CountWidth-1:0] cnt);
    dir_row_t d;
    d.w.value             = v;
    d.w.end_of_list       = eol;
    d.chk                 = chk;
    d.want.out_value      = v;
    d.want.kept           = kept;
    d.want.removed_count  = cnt;
    d.want.table_overflow = 1'b0;
    d.want.last           = eol;
    return d;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    err_count++;
  endtask

  task automatic send_word(sdr_pkg::in_word_t w, bit chk, sdr_pkg::out_word_t typed);
    sdr_pkg::out_word_t pred;
    int                 gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    pred = dedup_predict(w);
    expected_words.push_back(chk ? typed : pred);
    @(negedge clk_i);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_list(int len, bit wide);
    logic [sdr_pkg::ValueWidth-1:0] pool [8];
    logic [sdr_pkg::ValueWidth-1:0] sent_vals [$];
    sdr_pkg::in_word_t              w;
    int                             pick;
    foreach (pool[k]) begin
      case ($urandom_range(0, 9))
        0: pool[k] = {1'b1, {(sdr_pkg::ValueWidth-1){1'b0}}};
        1: pool[k] = {1'b0, {(sdr_pkg::ValueWidth-1){1'b1}}};
        2: pool[k] = '1;
        3: pool[k] = '0;
        default: pool[k] = $urandom;
      endcase
    end
    for (int i = 0; i < len; i++) begin
      if (wide) begin
        if (i < 3 || $urandom_range(0, 3) != 0) w.value = $urandom;
        else w.value = sent_vals[$urandom_range(0, sent_vals.size() - 1)];
      end else begin
        pick = $urandom_range(0, 9);
        w.value = (pick < 8) ? pool[pick] : $urandom;
      end
      sent_vals.push_back(w.value);
      w.end_of_list = (i == len - 1);
      send_word(w, 1'b0, '0);
    end
  endtask

  always @(negedge clk_i) begin
    if (!idle_on) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report("unexpected word", 64'(out_word), '0);
      end else begin
        oldest = expected_words.pop_front();
        if (out_word.out_value != oldest.out_value)
          report("out_value", 64'(out_word.out_value), 64'(oldest.out_value));
        if (out_word.kept != oldest.kept)
          report("kept", 64'(out_word.kept), 64'(oldest.kept));
        if (out_word.removed_count != oldest.removed_count)
          report("removed_count", 64'(out_word.removed_count), 64'(oldest.removed_count));
        if (out_word.table_overflow != oldest.table_overflow)
          report("table_overflow", 64'(out_word.table_overflow),
                 64'(oldest.table_overflow));
        if (out_word.last != oldest.last)
          report("last", 64'(out_word.last), 64'(oldest.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout");
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    int lists;
    int len;
    foreach (seen_ok[i]) seen_ok[i] = 1'b0;
    steps.push_back(row(32'h8000_0000, 1'b1, 1'b1, 1'b1, 16'd0));
    steps.push_back(row(32'h7FFF_FFFF, 1'b1, 1'b1, 1'b1, 16'd0));
    steps.push_back(row(32'h0000_0000, 1'b1, 1'b1, 1'b1, 16'd0));
    steps.push_back(row(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 16'd0));
    steps.push_back(row(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 16'd1));
    steps.push_back(row(32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1, 16'd1));
    steps.push_back(row(32'h8000_0000, 1'b0, 1'b0, 1'b0, 16'd0));
    steps.push_back(row(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 16'd0));
    steps.push_back(row(32'h8000_0000, 1'b0, 1'b0, 1'b0, 16'd0));
    steps.push_back(row(32'h7FFF_FFFE, 1'b0, 1'b0, 1'b0, 16'd0));
    steps.push_back(row(32'h0000_0000, 1'b1, 1'b0, 1'b0, 16'd0));
    steps.push_back(row(32'h0000_0005, 1'b0, 1'b1, 1'b1, 16'd0));
    steps.push_back(row(32'h0000_0005, 1'b1, 1'b1, 1'b0, 16'd1));
    steps.push_back(row(32'h0000_0005, 1'b1, 1'b1, 1'b1, 16'd0));
    steps.push_back(row(32'h5555_5555, 1'b0, 1'b0, 1'b0, 16'd0));
    steps.push_back(row(32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, 16'd0));
    steps.push_back(row(32'h5555_5555, 1'b1, 1'b0, 1'b0, 16'd0));

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    idle_on = 1'b1;
    foreach (steps[i]) send_word(steps[i].w, steps[i].chk, steps[i].want);
    drain();

    sent = 0;
    lists = 0;
    while (sent < RandomWords) begin
      if (lists % 20 == 10) drain();
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 11) == 0) begin
        len = $urandom_range(Depth + 2, Depth + 30);
        send_list(len, 1'b1);
      end else begin
        len = $urandom_range(1, 16);
        send_list(len, 1'b0);
      end
      sent += len;
      lists++;
    end

    idle_on = 1'b0;
    send_list(Depth + 8, 1'b1);
    send_list(4, 1'b0);

    drain();
    repeat (Depth + 10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[stream_duplicate_remover.f]
src/sdr_pkg.sv
src/sdr_cell.sv
src/sdr_out_stage.sv
src/stream_duplicate_remover.sv
src/sdr_checker.sv
test/testbench.sv
